>>> rtl/hbpg_pkg.sv
package hbpg_pkg;

	// hue sextant, 60 degrees each
	typedef enum logic [2:0] {
		SEXT_RED_YEL = 3'd0,
		SEXT_YEL_GRN = 3'd1,
		SEXT_GRN_CYN = 3'd2,
		SEXT_CYN_BLU = 3'd3,
		SEXT_BLU_MAG = 3'd4,
		SEXT_MAG_RED = 3'd5
	} sext_t;

	localparam int unsigned TONE_W  = 10;
	localparam int unsigned LEVEL_W = 7;
	localparam int unsigned COLOR_W = 24;
	localparam int unsigned CHAN_W  = 8;

	localparam int unsigned LEVEL_MAX = 100;
	localparam int unsigned TONE_MAX  = 359;

	// blend weights toward text, per mille
	localparam int unsigned NUM_BLENDS = 5;
	localparam int unsigned BLEND_K [NUM_BLENDS] = '{80, 35, 350, 600, 120};

	// reciprocal constants: floor(n/100), floor(n/25), floor(n/125)
	localparam int unsigned RCP100_K = 5243;
	localparam int unsigned RCP100_S = 19;
	localparam int unsigned RCP25_K  = 10486;
	localparam int unsigned RCP25_S  = 18;
	localparam int unsigned RCP125_K = 33555;
	localparam int unsigned RCP125_S = 22;

endpackage

>>> rtl/hbpg_chan.sv
module hbpg_chan (
	input  logic                                  clk,
	input  logic signed [hbpg_pkg::TONE_W-1:0]    tone,
	input  logic        [hbpg_pkg::LEVEL_W-1:0]   level,
	output logic        [hbpg_pkg::COLOR_W-1:0]   color
);

	// stage 1: clamp, sextant, ramp weight
	logic [6:0]            lvl_c;
	logic [8:0]            t_c;
	logic [1:0]            pair_c;
	logic [8:0]            m_c;
	logic                  half_c;
	logic [5:0]            w_c;

	logic [6:0]            lvl_s1;
	logic                  grey_s1;
	hbpg_pkg::sext_t       sext_s1;
	logic [5:0]            w_s1;

	always_comb begin
		lvl_c = (level > 7'(hbpg_pkg::LEVEL_MAX)) ? 7'(hbpg_pkg::LEVEL_MAX) : level;
		t_c   = (tone[8:0] > 9'(hbpg_pkg::TONE_MAX)) ? 9'(hbpg_pkg::TONE_MAX) : tone[8:0];
		if (t_c >= 9'd240) begin
			pair_c = 2'd2;
			m_c    = t_c - 9'd240;
		end else if (t_c >= 9'd120) begin
			pair_c = 2'd1;
			m_c    = t_c - 9'd120;
		end else begin
			pair_c = 2'd0;
			m_c    = t_c;
		end
		half_c = (m_c >= 9'd60);
		w_c    = half_c ? 6'(9'd120 - m_c) : m_c[5:0];
	end

	always_ff @(posedge clk) begin
		lvl_s1  <= lvl_c;
		grey_s1 <= tone[9];
		sext_s1 <= hbpg_pkg::sext_t'({pair_c, half_c});
		w_s1    <= w_c;
	end

	// stage 2: level times ramp weight, value numerator
	logic [12:0]           p_s2;
	logic [14:0]           vn_s2;
	logic                  grey_s2;
	hbpg_pkg::sext_t       sext_s2;

	always_ff @(posedge clk) begin
		p_s2    <= 13'(lvl_s1) * 13'(w_s1);
		vn_s2   <= 15'(lvl_s1) * 15'd255 + 15'd50;
		grey_s2 <= grey_s1;
		sext_s2 <= sext_s1;
	end

	// stage 3: value channel, ramp numerator over 16
	logic [27:0]           vprod;
	logic [17:0]           xn;
	logic [7:0]            v_s3;
	logic [12:0]           xq_s3;
	logic                  grey_s3;
	hbpg_pkg::sext_t       sext_s3;

	assign vprod = 28'(vn_s2) * 28'(hbpg_pkg::RCP100_K);
	assign xn    = 18'(p_s2) * 18'd17 + 18'd200;

	always_ff @(posedge clk) begin
		v_s3    <= vprod[hbpg_pkg::RCP100_S +: 8];
		xq_s3   <= xn[16:4];
		grey_s3 <= grey_s2;
		sext_s3 <= sext_s2;
	end

	// stage 4: ramp channel, divide by 25
	logic [26:0]           xprod;
	logic [7:0]            x_s4;
	logic [7:0]            v_s4;
	logic                  grey_s4;
	hbpg_pkg::sext_t       sext_s4;

	assign xprod = 27'(xq_s3) * 27'(hbpg_pkg::RCP25_K);

	always_ff @(posedge clk) begin
		x_s4    <= xprod[hbpg_pkg::RCP25_S +: 8];
		v_s4    <= v_s3;
		grey_s4 <= grey_s3;
		sext_s4 <= sext_s3;
	end

	// stage 5: channel placement
	logic [23:0]           rgb_c;
	logic [23:0]           color_s5;

	always_comb begin
		if (grey_s4) begin
			rgb_c = {v_s4, v_s4, v_s4};
		end else begin
			case (sext_s4)
				hbpg_pkg::SEXT_RED_YEL: rgb_c = {v_s4, x_s4, 8'd0};
				hbpg_pkg::SEXT_YEL_GRN: rgb_c = {x_s4, v_s4, 8'd0};
				hbpg_pkg::SEXT_GRN_CYN: rgb_c = {8'd0, v_s4, x_s4};
				hbpg_pkg::SEXT_CYN_BLU: rgb_c = {8'd0, x_s4, v_s4};
				hbpg_pkg::SEXT_BLU_MAG: rgb_c = {x_s4, 8'd0, v_s4};
				default:                rgb_c = {v_s4, 8'd0, x_s4};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		color_s5 <= rgb_c;
	end

	assign color = color_s5;

endmodule

>>> rtl/hue_brightness_palette_generator.sv
// Palette generator: converts a background and a text tone/brightness pair
// to full-saturation RGB and forms five blends of background toward text
// (8, 3.5, 35, 60 and 12 percent). The block is a 7-stage pipeline that takes
// one item every cycle: busy is never raised, an item is taken whenever start
// is high, and its results appear on the result ports for one cycle, marked
// by done. The receiver cannot stall, so the pipeline always advances; the
// divide-by-constant steps are reciprocal multiplies, each followed by a
// register. A tone with its sign bit set is grey, tones above 359 act as 359,
// brightness above 100 acts as 100, and all rounding is half up.
module hue_brightness_palette_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [hbpg_pkg::TONE_W-1:0]  back_tone,
	input  logic        [hbpg_pkg::LEVEL_W-1:0] back_level,
	input  logic signed [hbpg_pkg::TONE_W-1:0]  fore_tone,
	input  logic        [hbpg_pkg::LEVEL_W-1:0] fore_level,
	output logic                                done,
	output logic        [hbpg_pkg::COLOR_W-1:0] back_color,
	output logic        [hbpg_pkg::COLOR_W-1:0] fore_color,
	output logic        [hbpg_pkg::COLOR_W-1:0] blend_eight,
	output logic        [hbpg_pkg::COLOR_W-1:0] blend_three_half,
	output logic        [hbpg_pkg::COLOR_W-1:0] blend_thirty_five,
	output logic        [hbpg_pkg::COLOR_W-1:0] blend_sixty,
	output logic        [hbpg_pkg::COLOR_W-1:0] blend_twelve
);

	localparam int unsigned DEPTH = 7;

	// valid bits, one per stage, in step with the payload
	logic [DEPTH-1:0] vld_q;

	// never stalls
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[DEPTH-2:0], start};
		end
	end

	// stages 1 to 5: tone to rgb, one pipe per color
	logic [23:0] back_s5;
	logic [23:0] fore_s5;

	hbpg_chan u_back (
		.clk   (clk),
		.tone  (back_tone),
		.level (back_level),
		.color (back_s5)
	);

	hbpg_chan u_fore (
		.clk   (clk),
		.tone  (fore_tone),
		.level (fore_level),
		.color (fore_s5)
	);

	// stage 6: blend numerators a*(1000-k) + b*k + 500, kept over 8
	// stage 7: divide by 125 through a reciprocal multiply
	logic [23:0] back_s6;
	logic [23:0] fore_s6;
	logic [23:0] back_s7;
	logic [23:0] fore_s7;
	logic [14:0] num_s6   [hbpg_pkg::NUM_BLENDS][3];
	logic [23:0] blend_s7 [hbpg_pkg::NUM_BLENDS];

	always_ff @(posedge clk) begin
		back_s6 <= back_s5;
		fore_s6 <= fore_s5;
		back_s7 <= back_s6;
		fore_s7 <= fore_s6;
	end

	for (genvar gb = 0; gb < hbpg_pkg::NUM_BLENDS; gb++) begin : g_blend
		localparam logic [9:0] KF = 10'(hbpg_pkg::BLEND_K[gb]);
		localparam logic [9:0] KB = 10'(1000 - hbpg_pkg::BLEND_K[gb]);

		for (genvar gc = 0; gc < 3; gc++) begin : g_chan
			logic [17:0] num;
			logic [30:0] prod;

			// channel gc sits at bits 8*gc +: 8 for both colors
			assign num = 18'(back_s5[8*gc +: 8]) * 18'(KB)
				+ 18'(fore_s5[8*gc +: 8]) * 18'(KF) + 18'd500;

			always_ff @(posedge clk) begin
				num_s6[gb][gc] <= num[17:3];
			end

			assign prod = 31'(num_s6[gb][gc]) * 31'(hbpg_pkg::RCP125_K);

			always_ff @(posedge clk) begin
				blend_s7[gb][8*gc +: 8] <= prod[hbpg_pkg::RCP125_S +: 8];
			end
		end
	end

	assign done              = vld_q[DEPTH-1];
	assign back_color        = back_s7;
	assign fore_color        = fore_s7;
	assign blend_eight       = blend_s7[0];
	assign blend_three_half  = blend_s7[1];
	assign blend_thirty_five = blend_s7[2];
	assign blend_sixty       = blend_s7[3];
	assign blend_twelve      = blend_s7[4];

endmodule
